FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/crd_pkg.sv
// Package: types, constants and the CRC byte update of the record decoder.
`timescale 1ns / 1ps
`default_nettype none
package crd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [WORD_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

   // Record layout offsets
   localparam logic [POS_W-1:0] POS_SCHEMA   = 5'd4;
   localparam logic [POS_W-1:0] POS_FLAGS    = 5'd5;
   localparam logic [POS_W-1:0] POS_STEPS    = 5'd6;
   localparam logic [POS_W-1:0] POS_RSVD     = 5'd7;
   localparam logic [POS_W-1:0] POS_SEQ      = 5'd8;
   localparam logic [POS_W-1:0] POS_GEN      = 5'd12;
   localparam logic [POS_W-1:0] POS_CRC_END  = 5'd16;
   localparam logic [POS_W-1:0] POS_REC_END  = 5'd20;
   localparam logic [POS_W-1:0] POS_LAST     = 5'd19;
   localparam logic [POS_W-1:0] POS_MAX      = 5'd31;

   // Magic bytes, byte k of the record in bits [8k +: 8]
   localparam logic [4*BYTE_W-1:0] MAGIC = {8'h58, 8'h4B, 8'h4E, 8'h49};

   localparam logic [BYTE_W-1:0] SCHEMA_RST    = 8'd1;
   localparam logic [BYTE_W-1:0] MIN_STEPS_RST = 8'd1;
   localparam logic [BYTE_W-1:0] MAX_STEPS_RST = 8'd255;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_VALUES = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCHEMA    = 2'd0,
      CSR_MIN_STEPS = 2'd1,
      CSR_MAX_STEPS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] schema_version;
      logic [BYTE_W-1:0] min_steps;
      logic [BYTE_W-1:0] max_steps;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } byte_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [WORD_W-1:0] sequence_res;
      logic [WORD_W-1:0] generation;
      logic              roles_swapped;
      logic [BYTE_W-1:0] step_count;
   } result_type;

   // Reflected CRC-32, one byte, bit-serial form unrolled.
   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {WORD_W{c[0]}});
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/checked_record_decoder_unit.sv
// Top level of the checked record decoder: CSRs, byte pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none
// Decodes 20-byte settings records that arrive one byte per req transaction,
// with req_last_byte set on the final byte. Each record is checked for the
// magic "INKX", the schema byte (CSR 0), a flag byte with no bit but bit 0 set, a
// zero reserved byte, the exact length and a reflected CRC-32 over bytes 0
// to 15 that must match the little-endian word in bytes 16 to 19. Records
// that pass are then checked for a nonzero sequence word and a step count
// within [min_steps, max_steps] (CSRs 1 and 2). One rsp transaction per
// record carries the status and, only on status ok, the decoded fields.
// Rate: one byte per clock cycle while rsp does not stall, with no gaps between
// records; the eight-bit unrolled CRC update of the parser is the per-cycle work.
// Latency: a record's result shows on rsp the cycle after its last byte
// leaves the input register, so with no stalls the rsp transaction follows the
// req transaction of the last byte through the input register, then the result
// register. A held result blocks only a final byte from leaving the input register;
// while that byte waits there, req stalls. CSRs are always ready; the user must
// write them only while no record is in flight, as the block does not enforce it.
module checked_record_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_sequence_res,
   output logic [31:0]      rsp_generation,
   output logic             rsp_roles_swapped,
   output logic [7:0]       rsp_step_count,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import crd_pkg::*;

   cfg_type    cfg_ff;
   byte_type   held_byte;
   result_type result;
   logic       advance;
   logic       out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff;
   logic [WORD_W-1:0] seq_ff;
   logic [WORD_W-1:0] gen_ff;
   logic              swap_ff;
   logic [BYTE_W-1:0] steps_ff;

   // CSR writes: always accepted, unknown indexes drop
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.schema_version <= SCHEMA_RST;
         cfg_ff.min_steps      <= MIN_STEPS_RST;
         cfg_ff.max_steps      <= MAX_STEPS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SCHEMA:    cfg_ff.schema_version <= csr_wdata;
            CSR_MIN_STEPS: cfg_ff.min_steps      <= csr_wdata;
            CSR_MAX_STEPS: cfg_ff.max_steps      <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // The result register frees up this cycle if empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Advance a held byte; a final byte must also find room for its result
   assign advance  = held_byte.valid && (!held_byte.last_byte || out_free);

   crd_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .byte_out      (held_byte)
   );

   crd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .byte_in (held_byte),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // Result register: load a new result, drop a taken one, otherwise hold
   assign rsp_valid_in = result.valid ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         status_ff <= result.status;
         seq_ff    <= result.sequence_res;
         gen_ff    <= result.generation;
         swap_ff   <= result.roles_swapped;
         steps_ff  <= result.step_count;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_sequence_res  = seq_ff;
   assign rsp_generation    = gen_ff;
   assign rsp_roles_swapped = swap_ff;
   assign rsp_step_count    = steps_ff;

`include "assert_macros.svh"
   `ASSERT_IMPL(a_fields_zero_on_error, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_sequence_res == '0) && (rsp_generation == '0) && !rsp_roles_swapped && (rsp_step_count == '0))
   `ASSERT_IMPL(a_ok_has_sequence, clock, reset, rsp_valid && (rsp_status == STATUS_OK), rsp_sequence_res != '0)
   `ASSERT_IMPL(a_no_result_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !result.valid)

endmodule
`default_nettype wire

FILE: hdl/crd_in_reg.sv
// Input register stage: holds one byte transaction until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module crd_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_last_byte,
   input  wire logic               advance,
   output crd_pkg::byte_type       byte_out
);
   import crd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;

   // Stall only while a held byte cannot move on this cycle
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign byte_out.valid     = valid_ff;
   assign byte_out.data_byte = data_ff;
   assign byte_out.last_byte = last_ff;

`include "assert_macros.svh"
   `ASSERT_NEXT(a_held_byte_kept, clock, reset, valid_ff && !advance, valid_ff && $stable(data_ff) && $stable(last_ff))

endmodule
`default_nettype wire

FILE: hdl/crd_parser.sv
// Record parser: per-byte field capture, checks, CRC update and final status.
`timescale 1ns / 1ps
`default_nettype none
module crd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire crd_pkg::byte_type  byte_in,
   input  wire crd_pkg::cfg_type   cfg,
   output crd_pkg::result_type     result
);
   import crd_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] crc_ff, crc_in;
   logic              fmt_ff, fmt_in;
   logic [WORD_W-1:0] seq_ff, seq_in;
   logic [WORD_W-1:0] gen_ff, gen_in;
   logic [WORD_W-1:0] chk_ff, chk_in;
   logic              flag_ff, flag_in;
   logic [BYTE_W-1:0] steps_ff, steps_in;

   logic [BYTE_W-1:0] b;
   logic [WORD_W-1:0] lane_word;
   status_type        status;
   logic              done;

   assign b         = byte_in.data_byte;
   // Word fields start on four-byte boundaries, so the low position bits pick the lane
   assign lane_word = {{(WORD_W-BYTE_W){1'b0}}, b} << {pos_ff[1:0], 3'b000};
   assign done      = advance && byte_in.last_byte;

   always_comb begin
      pos_in   = (pos_ff < POS_MAX) ? pos_ff + 5'd1 : pos_ff;
      crc_in   = (pos_ff < POS_CRC_END) ? crc_byte(crc_ff, b) : crc_ff;
      fmt_in   = fmt_ff;
      seq_in   = seq_ff;
      gen_in   = gen_ff;
      chk_in   = chk_ff;
      flag_in  = flag_ff;
      steps_in = steps_ff;
      if (pos_ff < POS_SCHEMA) begin
         if (b != MAGIC[{pos_ff[1:0], 3'b000} +: BYTE_W]) fmt_in = 1'b1;
      end else if (pos_ff == POS_SCHEMA) begin
         if (b != cfg.schema_version) fmt_in = 1'b1;
      end else if (pos_ff == POS_FLAGS) begin
         if (b[BYTE_W-1:1] != '0) fmt_in = 1'b1;
         flag_in = b[0];
      end else if (pos_ff == POS_STEPS) begin
         steps_in = b;
      end else if (pos_ff == POS_RSVD) begin
         if (b != '0) fmt_in = 1'b1;
      end else if (pos_ff < POS_GEN) begin
         seq_in = seq_ff | lane_word;
      end else if (pos_ff < POS_CRC_END) begin
         gen_in = gen_ff | lane_word;
      end else if (pos_ff < POS_REC_END) begin
         chk_in = chk_ff | lane_word;
      end else begin
         fmt_in = 1'b1;
      end
   end

   always_comb begin
      if (fmt_in || (pos_ff != POS_LAST) || ((crc_in ^ CRC_ONES) != chk_in)) begin
         status = STATUS_FORMAT;
      end else if ((seq_in == '0) || (steps_in < cfg.min_steps) ||
                   (steps_in > cfg.max_steps)) begin
         status = STATUS_VALUES;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      result.valid         = done;
      result.status        = status;
      result.sequence_res  = (status == STATUS_OK) ? seq_in : '0;
      result.generation    = (status == STATUS_OK) ? gen_in : '0;
      result.roles_swapped = (status == STATUS_OK) ? flag_in : 1'b0;
      result.step_count    = (status == STATUS_OK) ? steps_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || done) begin
         pos_ff   <= '0;
         crc_ff   <= CRC_ONES;
         fmt_ff   <= 1'b0;
         seq_ff   <= '0;
         gen_ff   <= '0;
         chk_ff   <= '0;
         flag_ff  <= 1'b0;
         steps_ff <= '0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         fmt_ff   <= fmt_in;
         seq_ff   <= seq_in;
         gen_ff   <= gen_in;
         chk_ff   <= chk_in;
         flag_ff  <= flag_in;
         steps_ff <= steps_in;
      end
   end

endmodule
`default_nettype wire
